// ===== hdl/ppcm_pkg.sv =====
`timescale 1ns / 1ps

package ppcm_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_WRITE,
    ST_START,
    ST_RD,
    ST_ACC,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_DONE
  } state_t;

  localparam logic [7:0] SAMPLE_CENTER = 8'h80;
  localparam logic [7:0] SAMPLE_CLIP   = 8'hFE;
  localparam logic [7:0] SAMPLE_FLOOR  = 8'h00;

  // Ceiling sits this far above the center, two short of the floor's distance below it
  localparam logic [7:0] CLIP_UP_SPAN  = SAMPLE_CLIP - SAMPLE_CENTER;

endpackage

// ===== hdl/ppcm_scale.sv =====
`timescale 1ns / 1ps

module ppcm_scale #(
  parameter int SUM_W      = 11,
  parameter int VOLUME_MAX = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [7:0]              volume,
  output logic                    valid,
  output logic [7:0]              sample
);
  import ppcm_pkg::*;

  localparam int PROD_W = SUM_W + 9;
  localparam int MAG_W  = PROD_W - 1;
  localparam int L      = $clog2(VOLUME_MAX);
  localparam int SHIFT  = MAG_W + L;
  localparam int RW     = MAG_W + 2;
  localparam int QP_W   = MAG_W + RW;
  // ceil(2^SHIFT / VOLUME_MAX): exact floor division for any MAG_W-bit magnitude
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + VOLUME_MAX - 1) / VOLUME_MAX;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

  logic signed [PROD_W-1:0] prod;
  logic                     neg;
  logic [MAG_W-1:0]         quo;
  logic [MAG_W-1:0]         mag;
  logic [QP_W-1:0]          quo_full;
  logic                     v1;
  logic                     v2;

  assign mag      = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
  assign quo_full = QP_W'(mag) * QP_W'(RECIP_V);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= start;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    prod <= sum * $signed({1'b0, volume});
    neg  <= prod[PROD_W-1];
    quo  <= MAG_W'(quo_full >> SHIFT);
    if (neg) begin
      sample <= (quo >= MAG_W'(SAMPLE_CENTER)) ? SAMPLE_FLOOR
                                               : 8'(MAG_W'(SAMPLE_CENTER) - quo);
    end else begin
      sample <= (quo >= MAG_W'(CLIP_UP_SPAN)) ? SAMPLE_CLIP
                                              : 8'(MAG_W'(SAMPLE_CENTER) + quo);
    end
  end

endmodule

// ===== hdl/priority_pcm_channel_mixer.sv =====
`timescale 1ns / 1ps

// Mixer for up to CHANNEL_COUNT channels of unsigned 8-bit PCM kept in an internal
// sample memory with one port. Every input word gives one result word. A write or start
// word first goes through address reduction when SAMPLE_MEM_DEPTH is below 65536. A tick
// word visits the channels one at a time through the single memory read port (a read
// state and an accumulate state each), then runs the sum through a three-stage volume
// scaler with two multipliers. No new word is taken until the last one reaches the result
// register. The result register lets the next word in while the last result waits.
// Sample memory content is undefined until written; no clearing is done after reset.
module priority_pcm_channel_mixer #(
  parameter int CHANNEL_COUNT    = 4,
  parameter int VOLUME_MAX       = 8,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [15:0] write_address,
  input  logic [7:0]  write_byte,
  input  logic [1:0]  channel,
  input  logic [7:0]  priority_req,
  input  logic [15:0] start_address,
  input  logic [16:0] sound_length,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_volume,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  mixed_sample,
  output logic [3:0]  done_mask,
  output logic        start_accepted
);
  import ppcm_pkg::*;

  localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int MEM_AW = $clog2(SAMPLE_MEM_DEPTH);
  localparam int SUM_W  = $clog2(CHANNEL_COUNT) + 9;
  localparam bit RED_EN = (SAMPLE_MEM_DEPTH < 65536);
  localparam int JMAX   = RED_EN ? (16 - MEM_AW) : 0;
  localparam logic [16:0] RED_DIV = 17'(SAMPLE_MEM_DEPTH);
  localparam logic [MEM_AW-1:0] IDX_LAST = MEM_AW'(SAMPLE_MEM_DEPTH - 1);

  state_t state, state_next;

  // captured word
  req_t        req_r;
  logic [15:0] addr_r;
  logic [15:0] red;
  logic [3:0]  red_step;
  logic [7:0]  byte_r;
  logic [7:0]  prio_r;
  logic [16:0] len_r;
  logic        ch_ok;
  logic [CH_W-1:0] ch;

  // per-channel state
  logic [15:0]       ch_addr [CHANNEL_COUNT];
  logic [MEM_AW-1:0] ch_idx  [CHANNEL_COUNT];
  logic [16:0]       ch_rem  [CHANNEL_COUNT];
  logic [7:0]        ch_prio [CHANNEL_COUNT];

  logic [7:0] mem [SAMPLE_MEM_DEPTH];
  logic [7:0] rd_data;

  logic [7:0]              volume;
  logic signed [SUM_W-1:0] sum;
  logic [7:0]              res_sample;
  logic [3:0]              res_mask;
  logic                    res_acc;

  logic scale_valid;
  logic [7:0] scale_sample;

  // control decode
  logic accept, red_do, mem_wr, mem_rd, acc_do, start_do, scale_go, out_load;
  logic last_ch, active, take;
  logic [16:0] red_sub;
  logic [7:0]  cur_prio;
  logic signed [8:0] centered;

  assign last_ch  = (ch == CH_W'(CHANNEL_COUNT - 1));
  assign active   = (ch_rem[ch] != 17'd0);
  assign cur_prio = active ? ch_prio[ch] : 8'd0;
  assign take     = ch_ok && (prio_r > cur_prio);
  assign red_sub  = RED_DIV << red_step;
  assign centered = $signed({1'b0, rd_data}) - $signed({1'b0, SAMPLE_CENTER});
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (req_t'(req_type))
            REQ_WRITE: state_next = RED_EN ? ST_REDUCE : ST_WRITE;
            REQ_START: state_next = RED_EN ? ST_REDUCE : ST_START;
            REQ_TICK:  state_next = ST_RD;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_REDUCE: begin
        if (red_step == 4'd0) begin
          state_next = (req_r == REQ_WRITE) ? ST_WRITE : ST_START;
        end
      end
      ST_WRITE:      state_next = ST_DONE;
      ST_START:      state_next = ST_DONE;
      ST_RD:         state_next = ST_ACC;
      ST_ACC:        state_next = last_ch ? ST_SCALE_GO : ST_RD;
      ST_SCALE_GO:   state_next = ST_SCALE_WAIT;
      ST_SCALE_WAIT: state_next = scale_valid ? ST_DONE : ST_SCALE_WAIT;
      ST_DONE:       state_next = out_load ? ST_IDLE : ST_DONE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    accept   = 1'b0;
    red_do   = 1'b0;
    mem_wr   = 1'b0;
    mem_rd   = 1'b0;
    acc_do   = 1'b0;
    start_do = 1'b0;
    scale_go = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:     accept   = in_valid;
      ST_REDUCE:   red_do   = 1'b1;
      ST_WRITE:    mem_wr   = 1'b1;
      ST_START:    start_do = 1'b1;
      ST_RD:       mem_rd   = 1'b1;
      ST_ACC:      acc_do   = 1'b1;
      ST_SCALE_GO: scale_go = 1'b1;
      ST_DONE:     out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume <= 8'(VOLUME_MAX);
    end else if (cfg_we) begin
      volume <= ({4'd0, cfg_volume} > 8'(VOLUME_MAX)) ? 8'(VOLUME_MAX) : {4'd0, cfg_volume};
    end
  end

  // captured word and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= req_t'(req_type);
      addr_r     <= (req_t'(req_type) == REQ_WRITE) ? write_address : start_address;
      red        <= (req_t'(req_type) == REQ_WRITE) ? write_address : start_address;
      red_step   <= 4'(JMAX);
      byte_r     <= write_byte;
      prio_r     <= priority_req;
      len_r      <= sound_length;
      ch_ok      <= ({3'd0, channel} < 5'(CHANNEL_COUNT));
      ch         <= ((req_t'(req_type) == REQ_START) &&
                     ({3'd0, channel} < 5'(CHANNEL_COUNT))) ? CH_W'(channel) : '0;
      sum        <= '0;
      res_sample <= SAMPLE_FLOOR;
      res_mask   <= 4'd0;
      res_acc    <= 1'b0;
    end else begin
      if (red_do) begin
        // restoring reduction of the address by the memory depth, one shift a cycle
        if ({1'b0, red} >= red_sub) begin
          red <= 16'({1'b0, red} - red_sub);
        end
        red_step <= red_step - 4'd1;
      end
      if (start_do) begin
        res_acc <= take;
      end
      if (acc_do) begin
        if (active) begin
          sum <= sum + SUM_W'(centered);
          if (ch_rem[ch] == 17'd1) begin
            res_mask <= res_mask | (4'd1 << ch);  // channels above 3 shift out
          end
        end
        if (!last_ch) begin
          ch <= ch + 1'b1;
        end
      end
      if (scale_valid) begin
        res_sample <= scale_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        ch_addr[i] <= 16'd0;
        ch_idx[i]  <= '0;
        ch_rem[i]  <= 17'd0;
        ch_prio[i] <= 8'd0;
      end
    end else if (start_do && take) begin
      ch_prio[ch] <= prio_r;
      ch_addr[ch] <= addr_r;
      ch_idx[ch]  <= MEM_AW'(red);
      ch_rem[ch]  <= len_r;
    end else if (acc_do && active) begin
      ch_rem[ch]  <= ch_rem[ch] - 17'd1;
      ch_addr[ch] <= ch_addr[ch] + 16'd1;
      // memory index follows the 16-bit address modulo the depth
      ch_idx[ch]  <= ((ch_addr[ch] == 16'hFFFF) || (ch_idx[ch] == IDX_LAST)) ? '0
                   : ch_idx[ch] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[MEM_AW'(red)] <= byte_r;
    end
    if (mem_rd) begin
      rd_data <= mem[ch_idx[ch]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mixed_sample   <= res_sample;
      done_mask      <= res_mask;
      start_accepted <= res_acc;
    end
  end

  ppcm_scale #(
    .SUM_W      (SUM_W),
    .VOLUME_MAX (VOLUME_MAX)
  ) u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (scale_go),
    .sum    (sum),
    .volume (volume),
    .valid  (scale_valid),
    .sample (scale_sample)
  );

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result word loaded outside the done state");

  a_scale_in_wait: assert property (@(posedge clk) disable iff (rst)
    scale_valid |-> state == ST_SCALE_WAIT)
    else $error("scaler result arrived outside its wait state");

  a_reduce_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE && red_step == 4'd0) |=> (!RED_EN || ({1'b0, red} < RED_DIV)))
    else $error("address reduction left an index beyond the memory depth");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mixed_sample <= SAMPLE_CLIP)
    else $error("mixed sample above clip ceiling");

endmodule

// ===== tb/priority_pcm_channel_mixer_tb.sv =====
`timescale 1ns / 1ps

module priority_pcm_channel_mixer_tb;
  import ppcm_pkg::*;

  localparam int CHANNELS     = 4;
  localparam int VOL_FULL     = 8;
  localparam int MEM_WORDS    = 65536;
  localparam int PHASE_WORDS  = 160;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    req_t        kind;
    logic [15:0] waddr;
    logic [7:0]  wbyte;
    logic [1:0]  ch;
    logic [7:0]  prio;
    logic [15:0] saddr;
    logic [16:0] len;
  } mixer_word_t;

  typedef struct {
    logic [7:0] sample;
    logic [3:0] done;
    logic       accepted;
  } mix_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_t;

  // Channel state tracker and result predictor
  class mix_predictor;
    logic [7:0]  sample_mem [0:MEM_WORDS-1];
    bit          written [0:MEM_WORDS-1];
    logic [15:0] rd_addr [0:CHANNELS-1];
    logic [16:0] remaining [0:CHANNELS-1];
    logic [7:0]  prio [0:CHANNELS-1];
    int          volume;
    int          errors;
    mix_result_t expected_results [$];

    function new();
      for (int i = 0; i < CHANNELS; i++) begin
        rd_addr[i]   = '0;
        remaining[i] = '0;
        prio[i]      = '0;
      end
      volume = VOL_FULL;
      errors = 0;
    endfunction

    function void set_volume(logic [3:0] v);
      volume = (int'(v) > VOL_FULL) ? VOL_FULL : int'(v);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void take_word(mixer_word_t w);
      mix_result_t r;
      int          sum;
      int          scaled;
      logic [7:0]  current;
      r.sample   = '0;
      r.done     = '0;
      r.accepted = 1'b0;
      case (w.kind)
        REQ_WRITE: begin
          sample_mem[w.waddr] = w.wbyte;
          written[w.waddr]    = 1'b1;
        end
        REQ_START: begin
          current = (remaining[w.ch] != 0) ? prio[w.ch] : 8'd0;
          if (w.prio > current) begin
            prio[w.ch]      = w.prio;
            rd_addr[w.ch]   = w.saddr;
            remaining[w.ch] = w.len;
            r.accepted      = 1'b1;
          end
        end
        REQ_TICK: begin
          sum = 0;
          for (int i = 0; i < CHANNELS; i++) begin
            if (remaining[i] != 0) begin
              remaining[i] = remaining[i] - 17'd1;
              sum += int'(sample_mem[rd_addr[i]]) - 128;
              rd_addr[i] = rd_addr[i] + 16'd1;
              if (remaining[i] == 0) r.done[i] = 1'b1;
            end
          end
          // int division truncates toward zero
          scaled = (sum * volume) / VOL_FULL + 128;
          if (scaled > 254) scaled = 254;
          else if (scaled < 0) scaled = 0;
          r.sample = scaled[7:0];
        end
        default: ;
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [7:0] sample, logic [3:0] done, logic accepted);
      mix_result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word: sample %0d done %0h accepted %0d",
                 $time, sample, done, accepted);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (sample !== e.sample) begin
        $display("%0t: mixed_sample expected %0d actual %0d", $time, e.sample, sample);
        errors++;
      end
      if (done !== e.done) begin
        $display("%0t: done_mask expected %0h actual %0h", $time, e.done, done);
        errors++;
      end
      if (accepted !== e.accepted) begin
        $display("%0t: start_accepted expected %0d actual %0d", $time, e.accepted, accepted);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [15:0] write_address = '0;
  logic [7:0]  write_byte = '0;
  logic [1:0]  channel = '0;
  logic [7:0]  priority_req = '0;
  logic [15:0] start_address = '0;
  logic [16:0] sound_length = '0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_volume = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  mixed_sample;
  logic [3:0]  done_mask;
  logic        start_accepted;

  mix_predictor   mixer;
  int             cycle_count = 0;
  int             words_sent = 0;
  int             burst_left = 4;
  stall_pattern_t stall_mode = STALL_NONE;
  int             stall_left = 50;

  priority_pcm_channel_mixer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .write_address  (write_address),
    .write_byte     (write_byte),
    .channel        (channel),
    .priority_req   (priority_req),
    .start_address  (start_address),
    .sound_length   (sound_length),
    .cfg_we         (cfg_we),
    .cfg_volume     (cfg_volume),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mixed_sample   (mixed_sample),
    .done_mask      (done_mask),
    .start_accepted (start_accepted)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stall pattern, switching between modes every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_pattern_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= (stall_left[1:0] == 2'd0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      mixer.check_result(mixed_sample, done_mask, start_accepted);
  end

  function automatic mixer_word_t random_word(req_t kind);
    mixer_word_t w;
    w.kind  = kind;
    w.waddr = 16'($urandom);
    w.wbyte = 8'($urandom);
    w.ch    = 2'($urandom);
    w.prio  = 8'($urandom);
    w.saddr = 16'($urandom);
    w.len   = 17'($urandom_range(0, 131071));
    return w;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_word(input mixer_word_t w);
    int gap;
    in_valid      <= 1'b1;
    req_type      <= w.kind;
    write_address <= w.waddr;
    write_byte    <= w.wbyte;
    channel       <= w.ch;
    priority_req  <= w.prio;
    start_address <= w.saddr;
    sound_length  <= w.len;
    do @(posedge clk); while (in_stall !== 1'b0);
    mixer.take_word(w);
    if (w.kind != REQ_NOP) words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
    mixer_word_t w;
    w = random_word(REQ_WRITE);
    w.waddr = addr;
    w.wbyte = data;
    send_word(w);
  endtask

  task automatic send_start(input logic [1:0] ch, input logic [7:0] prio,
                            input logic [15:0] addr, input logic [16:0] len);
    mixer_word_t w;
    w = random_word(REQ_START);
    w.ch    = ch;
    w.prio  = prio;
    w.saddr = addr;
    w.len   = len;
    send_word(w);
  endtask

  // Any live channel about to read a never-written byte gets it filled first
  task automatic send_tick();
    for (int i = 0; i < CHANNELS; i++) begin
      if (mixer.remaining[i] != 0 && !mixer.written[mixer.rd_addr[i]])
        send_write(mixer.rd_addr[i], pick_byte());
    end
    send_word(random_word(REQ_TICK));
  endtask

  task automatic send_random();
    int          r;
    logic [15:0] near;
    logic [16:0] len;
    r    = $urandom_range(0, 99);
    near = mixer.rd_addr[$urandom_range(0, CHANNELS - 1)] + 16'($urandom_range(0, 15));
    if (r < 28) begin
      send_write(($urandom_range(0, 1) != 0) ? near : 16'($urandom), pick_byte());
    end else if (r < 52) begin
      case ($urandom_range(0, 19))
        0, 1:    len = '0;
        2:       len = 17'($urandom_range(0, 131071));
        3, 4, 5: len = 17'($urandom_range(25, 2000));
        default: len = 17'($urandom_range(1, 24));
      endcase
      send_start(2'($urandom),
                 ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom),
                 ($urandom_range(0, 1) != 0) ? near : 16'($urandom), len);
    end else if (r < 96) begin
      send_tick();
    end else begin
      send_word(random_word(REQ_NOP));
    end
  endtask

  task automatic wait_idle();
    while (mixer.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [3:0] volumes [10];
    int         phase_start;
    volumes = '{4'd15, 4'd0, 4'd3, 4'd8, 4'd1, 4'd9, 4'd6, 4'd2, 4'd7, 4'd5};
    mixer = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Clip high with all four channels on 0xFF, then clip low on 0x00
    send_write(16'h0000, 8'hFF);
    send_write(16'h0001, 8'h00);
    send_write(16'hFFFF, 8'h7F);
    for (int i = 0; i < CHANNELS; i++) send_start(2'(i), 8'd1, 16'h0000, 17'd1);
    send_tick();
    for (int i = 0; i < CHANNELS; i++) send_start(2'(i), 8'd255, 16'h0001, 17'd1);
    send_tick();
    // equal or lower priority on a busy channel is rejected; read address wraps
    send_start(2'd0, 8'd5, 16'hFFFF, 17'd2);
    send_start(2'd0, 8'd5, 16'h0000, 17'd9);
    send_start(2'd0, 8'd4, 16'h0000, 17'd9);
    // zero length takes the channel but leaves it idle
    send_start(2'd1, 8'd200, 16'h1234, 17'd0);
    send_start(2'd1, 8'd1, 16'h0000, 17'd3);
    send_tick();
    send_tick();
    send_word(random_word(REQ_NOP));
    send_start(2'd2, 8'd100, 16'h8000, 17'h1FFFF);
    send_start(2'd3, 8'd0, 16'h0000, 17'd4);
    send_tick();
    send_tick();
    in_valid <= 1'b0;

    foreach (volumes[p]) begin
      wait_idle();
      cfg_we     <= 1'b1;
      cfg_volume <= volumes[p];
      @(posedge clk);
      mixer.set_volume(volumes[p]);
      cfg_we <= 1'b0;
      @(posedge clk);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) send_random();
      in_valid <= 1'b0;
    end

    while (mixer.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mixer.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ppcm_pkg.sv
hdl/ppcm_scale.sv
hdl/priority_pcm_channel_mixer.sv
tb/priority_pcm_channel_mixer_tb.sv
